// ===== design/gcmc_pkg.sv =====
`timescale 1ns / 1ps

package gcmc_pkg;

    // Width of one coefficient word (signed Q16.32).
    localparam int WORD_W = 48;

    // Number of buffer positions that the sample tag wraps at.
    localparam int INDEX_SLOTS = 256;

    typedef logic [2:0][15:0] t_vec16;
    typedef logic [2:0][47:0] t_vec48;
    typedef logic [2:0][31:0] t_vec32;

    // Sideband that rides along with a sample through the pipeline.
    typedef struct packed {
        logic [2:0] imu;
        logic [7:0] idx;
        t_vec16     accel;
    } t_side;

    typedef struct packed {
        logic        sat;
        logic [47:0] value;
    } t_acc_res;

    // Partial products of a 48 by 48 multiply, split at bit 32.
    typedef struct packed {
        logic [63:0] ll;
        logic [48:0] lh;
        logic [48:0] hl;
        logic [31:0] hh;
    } t_part;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } t_rate_res;

    typedef logic [255:0][7:0] t_idx_table;

    // Tag wrap table, built at elaboration.
    function automatic t_idx_table f_build_idx_table();
        t_idx_table t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'(i % INDEX_SLOTS);
        end
        return t;
    endfunction

    localparam t_idx_table IDX_MOD = f_build_idx_table();

    // Signed 48 by 16 product at full 64-bit width.
    function automatic logic [63:0] f_mul_48x16(input logic [47:0] a, input logic [15:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        sa = $signed({{16{a[47]}}, a});
        sb = $signed({{48{b[15]}}, b});
        return sa * sb;
    endfunction

    // One Horner step after the multiply: round half up by 15 bits, add the
    // next coefficient and clamp to the 48-bit range.
    function automatic t_acc_res f_horner_step(input logic [47:0] c, input logic [63:0] prod);
        logic signed [64:0] rnd;
        logic signed [64:0] sh;
        logic signed [49:0] sum;
        t_acc_res           r;
        rnd = $signed({prod[63], prod}) + 65'sd16384;
        sh  = rnd >>> 15;
        sum = $signed({{2{c[47]}}, c}) + $signed(sh[49:0]);
        r.sat = 1'b0;
        r.value = sum[47:0];
        if (sum > 50'sd140737488355327) begin
            r.sat = 1'b1;
            r.value = 48'h7FFF_FFFF_FFFF;
        end else if (sum < -50'sd140737488355328) begin
            r.sat = 1'b1;
            r.value = 48'h8000_0000_0000;
        end
        return r;
    endfunction

    // Four partial products of two signed 48-bit words.
    function automatic t_part f_partials(input logic [47:0] a, input logic [47:0] b);
        logic signed [48:0] a_lo;
        logic signed [48:0] b_lo;
        logic signed [48:0] a_hi;
        logic signed [48:0] b_hi;
        logic signed [31:0] a_hh;
        logic signed [31:0] b_hh;
        t_part              p;
        a_lo = $signed({17'b0, a[31:0]});
        b_lo = $signed({17'b0, b[31:0]});
        a_hi = $signed({{33{a[47]}}, a[47:32]});
        b_hi = $signed({{33{b[47]}}, b[47:32]});
        a_hh = $signed({{16{a[47]}}, a[47:32]});
        b_hh = $signed({{16{b[47]}}, b[47:32]});
        p.ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        p.lh = a_lo * b_hi;
        p.hl = a_hi * b_lo;
        p.hh = a_hh * b_hh;
        return p;
    endfunction

    // Recombine the partial products into the full 96-bit product.
    function automatic logic [95:0] f_combine(input t_part p);
        logic signed [49:0] mid;
        mid = $signed({p.lh[48], p.lh}) + $signed({p.hl[48], p.hl});
        return {p.hh, 64'b0} + {{14{mid[49]}}, mid, 32'b0} + {32'b0, p.ll};
    endfunction

    // Drop 48 fraction bits (rounding already added) and clamp to 32 bits.
    function automatic t_rate_res f_round_clamp(input logic [97:0] sum);
        logic signed [97:0] s;
        logic signed [49:0] q;
        t_rate_res          r;
        s = $signed(sum) >>> 48;
        q = $signed(s[49:0]);
        r.sat = 1'b0;
        r.value = q[31:0];
        if (q > 50'sd2147483647) begin
            r.sat = 1'b1;
            r.value = 32'h7FFF_FFFF;
        end else if (q < -50'sd2147483648) begin
            r.sat = 1'b1;
            r.value = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

// ===== design/gcmc_coef_mem.sv =====
`timescale 1ns / 1ps

module gcmc_coef_mem #(
    parameter int NUM_IMUS   = 6,
    parameter int POLY_TERMS = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((NUM_IMUS > 1) ? $clog2(NUM_IMUS) : 1)-1:0] i_wr_addr,
    input  logic [$clog2(3 * POLY_TERMS + 9)-1:0]   i_wr_slot,
    input  logic [gcmc_pkg::WORD_W-1:0]             i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((NUM_IMUS > 1) ? $clog2(NUM_IMUS) : 1)-1:0] i_rd_addr,
    output logic [3 * POLY_TERMS + 8:0][gcmc_pkg::WORD_W-1:0] o_rd_row
);

    localparam int ROWW = 3 * POLY_TERMS + 9;

    // One row per IMU; loads write a single word of a row.
    logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] r_mem [NUM_IMUS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_slot] <= i_wr_data;
        end
    end

    // Whole-row read with a registered output.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_row <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/gcmc_horner.sv =====
`timescale 1ns / 1ps

module gcmc_horner #(
    parameter int POLY_TERMS = 4
) (
    input  logic                                              i_clk,
    input  logic [2*(POLY_TERMS-1)-1:0]                       i_en,
    input  logic [3 * POLY_TERMS + 8:0][gcmc_pkg::WORD_W-1:0] i_row,
    input  gcmc_pkg::t_vec16                                  i_gyro,
    input  gcmc_pkg::t_side                                   i_side,
    output logic [3 * POLY_TERMS + 8:0][gcmc_pkg::WORD_W-1:0] o_row,
    output gcmc_pkg::t_vec48                                  o_lin,
    output logic                                              o_sat,
    output gcmc_pkg::t_side                                   o_side
);

    localparam int STEPS = POLY_TERMS - 1;
    localparam int ROWW  = 3 * POLY_TERMS + 9;

    // Multiply stage registers, one set per Horner step.
    logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] r_p_row  [STEPS];
    gcmc_pkg::t_vec16                      r_p_x    [STEPS];
    logic [2:0][63:0]                      r_p_prod [STEPS];
    logic                                  r_p_sat  [STEPS];
    gcmc_pkg::t_side                       r_p_side [STEPS];

    // Add stage registers, one set per Horner step.
    logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] r_a_row  [STEPS];
    gcmc_pkg::t_vec16                      r_a_x    [STEPS];
    gcmc_pkg::t_vec48                      r_a_acc  [STEPS];
    logic                                  r_a_sat  [STEPS];
    gcmc_pkg::t_side                       r_a_side [STEPS];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] w_row;
        gcmc_pkg::t_vec16                      w_x;
        gcmc_pkg::t_vec48                      w_acc;
        logic                                  w_sat;
        gcmc_pkg::t_side                       w_side;
        gcmc_pkg::t_acc_res                    w_res [3];

        // The first step starts from the top coefficient of each axis.
        if (j == 0) begin : g_first
            always_comb begin
                w_row  = i_row;
                w_x    = i_gyro;
                w_sat  = 1'b0;
                w_side = i_side;
                for (int a = 0; a < 3; a++) begin
                    w_acc[a] = i_row[a * POLY_TERMS + POLY_TERMS - 1];
                end
            end
        end else begin : g_next
            always_comb begin
                w_row  = r_a_row[j-1];
                w_x    = r_a_x[j-1];
                w_acc  = r_a_acc[j-1];
                w_sat  = r_a_sat[j-1];
                w_side = r_a_side[j-1];
            end
        end

        // Accumulator times the raw axis value.
        always_ff @(posedge i_clk) begin
            if (i_en[2*j]) begin
                r_p_row[j]  <= w_row;
                r_p_x[j]    <= w_x;
                r_p_sat[j]  <= w_sat;
                r_p_side[j] <= w_side;
                for (int a = 0; a < 3; a++) begin
                    r_p_prod[j][a] <= gcmc_pkg::f_mul_48x16(w_acc[a], w_x[a]);
                end
            end
        end

        // Round, add the next lower coefficient and clamp.
        always_comb begin
            for (int a = 0; a < 3; a++) begin
                w_res[a] = gcmc_pkg::f_horner_step(
                    r_p_row[j][a * POLY_TERMS + POLY_TERMS - 2 - j], r_p_prod[j][a]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[2*j+1]) begin
                r_a_row[j]  <= r_p_row[j];
                r_a_x[j]    <= r_p_x[j];
                r_a_side[j] <= r_p_side[j];
                r_a_sat[j]  <= r_p_sat[j] | w_res[0].sat | w_res[1].sat | w_res[2].sat;
                for (int a = 0; a < 3; a++) begin
                    r_a_acc[j][a] <= w_res[a].value;
                end
            end
        end
    end

    assign o_row  = r_a_row[STEPS-1];
    assign o_lin  = r_a_acc[STEPS-1];
    assign o_sat  = r_a_sat[STEPS-1];
    assign o_side = r_a_side[STEPS-1];

endmodule

// ===== design/gcmc_matrix.sv =====
`timescale 1ns / 1ps

module gcmc_matrix #(
    parameter int POLY_TERMS = 4
) (
    input  logic                                              i_clk,
    input  logic [3:0]                                        i_en,
    input  logic [3 * POLY_TERMS + 8:0][gcmc_pkg::WORD_W-1:0] i_row,
    input  gcmc_pkg::t_vec48                                  i_lin,
    input  logic                                              i_sat,
    input  gcmc_pkg::t_side                                   i_side,
    output gcmc_pkg::t_vec32                                  o_rate,
    output logic                                              o_sat,
    output gcmc_pkg::t_side                                   o_side
);

    localparam int MAT_BASE = 3 * POLY_TERMS;

    gcmc_pkg::t_part  r_m1_part [9];
    logic             r_m1_sat;
    gcmc_pkg::t_side  r_m1_side;

    logic [95:0]      r_m2_prod [9];
    logic             r_m2_sat;
    gcmc_pkg::t_side  r_m2_side;

    logic [97:0]      r_m3_sum [3];
    logic             r_m3_sat;
    gcmc_pkg::t_side  r_m3_side;

    gcmc_pkg::t_rate_res w_res [3];

    // Partial products of every matrix entry with its vector element.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_m1_sat  <= i_sat;
            r_m1_side <= i_side;
            for (int e = 0; e < 9; e++) begin
                r_m1_part[e] <= gcmc_pkg::f_partials(i_row[MAT_BASE + e], i_lin[e % 3]);
            end
        end
    end

    // Full products.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_m2_sat  <= r_m1_sat;
            r_m2_side <= r_m1_side;
            for (int e = 0; e < 9; e++) begin
                r_m2_prod[e] <= gcmc_pkg::f_combine(r_m1_part[e]);
            end
        end
    end

    // Row sums plus the rounding half.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m3_sat  <= r_m2_sat;
            r_m3_side <= r_m2_side;
            for (int r = 0; r < 3; r++) begin
                r_m3_sum[r] <= {{2{r_m2_prod[3*r][95]}}, r_m2_prod[3*r]}
                             + {{2{r_m2_prod[3*r+1][95]}}, r_m2_prod[3*r+1]}
                             + {{2{r_m2_prod[3*r+2][95]}}, r_m2_prod[3*r+2]}
                             + 98'h8000_0000_0000;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_res[r] = gcmc_pkg::f_round_clamp(r_m3_sum[r]);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_side <= r_m3_side;
            o_sat  <= r_m3_sat | w_res[0].sat | w_res[1].sat | w_res[2].sat;
            for (int r = 0; r < 3; r++) begin
                o_rate[r] <= w_res[r].value;
            end
        end
    end

endmodule

// ===== design/gyro_cubic_and_matrix_calibration.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                        Contents
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  load word or raw sample
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  calibrated sample
//
// One word is accepted per cycle unless all stages are full and stalled. A
// sample passes the coefficient row register, a multiply and an add register
// per Horner step, and the partial-product, full-product, row-sum and output
// registers of the matrix product. Loads write the memory in their accept
// cycle and leave no result. Reset clears only the stage valid flags. A stage
// holds while the next is full and stalled, so bubbles are squeezed out.

module gyro_cubic_and_matrix_calibration #(
    parameter int NUM_IMUS   = 6,
    parameter int POLY_TERMS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // imu[2:0], coef_slot[7:3], coef_value[55:8], sample_index[63:56],
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (16 bits each)
    input  logic [159:0] i_s_axis_tdata,
    // op
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // imu_out[2:0], index_out[10:3], rate_x, rate_y, rate_z (32 bits each),
    // accel_x_out, accel_y_out, accel_z_out (16 bits each), zero fill
    output logic [159:0] o_m_axis_tdata,
    // saturated
    output logic [0:0]   o_m_axis_tuser
);

    localparam int ROWW = 3 * POLY_TERMS + 9;
    localparam int AW   = (NUM_IMUS > 1) ? $clog2(NUM_IMUS) : 1;
    localparam int SW   = $clog2(ROWW);
    localparam int NS   = 2 * POLY_TERMS + 3;
    localparam int HS   = 2 * (POLY_TERMS - 1);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;
    logic          w_accept;
    logic          w_imu_ok;
    logic          w_op;
    logic [2:0]    w_imu;
    logic [4:0]    w_slot;

    gcmc_pkg::t_vec16 r_s0_gyro;
    gcmc_pkg::t_side  r_s0_side;

    logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] w_mem_row;
    logic [ROWW-1:0][gcmc_pkg::WORD_W-1:0] w_h_row;
    gcmc_pkg::t_vec48 w_lin;
    logic             w_h_sat;
    gcmc_pkg::t_side  w_h_side;
    gcmc_pkg::t_vec32 w_rate;
    logic             w_sat;
    gcmc_pkg::t_side  w_side;

    assign w_op     = i_s_axis_tuser[0];
    assign w_imu    = i_s_axis_tdata[2:0];
    assign w_slot   = i_s_axis_tdata[7:3];
    assign w_imu_ok = int'(w_imu) < NUM_IMUS;
    assign w_accept = i_s_axis_tvalid & w_en[0];

    // Stage enables: a stage loads when it is empty or its successor moves.
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int s = NS - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_accept & w_op & w_imu_ok;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage 0 sideband, aligned with the registered memory row.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_gyro[0]       <= i_s_axis_tdata[79:64];
            r_s0_gyro[1]       <= i_s_axis_tdata[95:80];
            r_s0_gyro[2]       <= i_s_axis_tdata[111:96];
            r_s0_side.imu      <= w_imu;
            r_s0_side.idx      <= gcmc_pkg::IDX_MOD[i_s_axis_tdata[63:56]];
            r_s0_side.accel[0] <= i_s_axis_tdata[127:112];
            r_s0_side.accel[1] <= i_s_axis_tdata[143:128];
            r_s0_side.accel[2] <= i_s_axis_tdata[159:144];
        end
    end

    gcmc_coef_mem #(
        .NUM_IMUS   (NUM_IMUS),
        .POLY_TERMS (POLY_TERMS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept & !w_op & w_imu_ok & (int'(w_slot) < ROWW)),
        .i_wr_addr (AW'(w_imu)),
        .i_wr_slot (SW'(w_slot)),
        .i_wr_data (i_s_axis_tdata[55:8]),
        .i_rd_en   (w_en[0]),
        .i_rd_addr (AW'(w_imu)),
        .o_rd_row  (w_mem_row)
    );

    gcmc_horner #(
        .POLY_TERMS (POLY_TERMS)
    ) u_horner (
        .i_clk  (i_clk),
        .i_en   (w_en[HS:1]),
        .i_row  (w_mem_row),
        .i_gyro (r_s0_gyro),
        .i_side (r_s0_side),
        .o_row  (w_h_row),
        .o_lin  (w_lin),
        .o_sat  (w_h_sat),
        .o_side (w_h_side)
    );

    gcmc_matrix #(
        .POLY_TERMS (POLY_TERMS)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_en   (w_en[NS-1:NS-4]),
        .i_row  (w_h_row),
        .i_lin  (w_lin),
        .i_sat  (w_h_sat),
        .i_side (w_h_side),
        .o_rate (w_rate),
        .o_sat  (w_sat),
        .o_side (w_side)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tuser  = w_sat;
    assign o_m_axis_tdata  = {5'b0, w_side.accel[2], w_side.accel[1], w_side.accel[0],
                              w_rate[2], w_rate[1], w_rate[0], w_side.idx, w_side.imu};

endmodule

// ===== dv/gcmc_tb_pkg.sv =====
`timescale 1ns / 1ps

package gcmc_tb_pkg;

    // Operation carried in tuser of an input word.
    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    localparam int NUM_IMUS   = 6;
    localparam int POLY_TERMS = 4;
    localparam int MAT_BASE   = 3 * POLY_TERMS;
    localparam int ROW_WORDS  = MAT_BASE + 9;

endpackage

// ===== dv/gcmc_scoreboard.sv =====
`timescale 1ns / 1ps

module gcmc_scoreboard
    import gcmc_tb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [159:0] i_s_tdata,
    input  logic [0:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [159:0] i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_rate_count,
    output int           o_sat_count
);

    localparam longint W48_MAX = 64'sd140737488355327;
    localparam longint W48_MIN = -64'sd140737488355328;

    typedef struct {
        logic [2:0]  imu;
        logic [7:0]  idx;
        logic [31:0] rate [3];
        logic [15:0] accel [3];
        logic        sat;
    } t_rate_word;

    // Shadow copy of the coefficient memory, sign-extended.
    longint     coef_shadow [NUM_IMUS * ROW_WORDS];
    t_rate_word rate_queue [$];

    // Works out the calibrated word for one sample from the shadow table.
    function automatic t_rate_word calibrate(input logic [159:0] d);
        t_rate_word         w;
        int                 base;
        longint             lin [3];
        longint             acc;
        longint             x;
        longint             step;
        logic signed [99:0] sum;
        logic signed [99:0] ma;
        logic signed [99:0] va;
        logic signed [99:0] q;
        base  = int'(d[2:0]) * ROW_WORDS;
        w.imu = d[2:0];
        w.idx = d[63:56];
        w.sat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            x   = longint'($signed(d[64 + 16 * a +: 16]));
            acc = coef_shadow[base + a * POLY_TERMS + POLY_TERMS - 1];
            for (int k = POLY_TERMS - 2; k >= 0; k--) begin
                step = (acc * x + 64'sd16384) >>> 15;
                acc  = coef_shadow[base + a * POLY_TERMS + k] + step;
                if (acc > W48_MAX) begin
                    acc   = W48_MAX;
                    w.sat = 1'b1;
                end else if (acc < W48_MIN) begin
                    acc   = W48_MIN;
                    w.sat = 1'b1;
                end
            end
            lin[a]   = acc;
            w.accel[a] = d[112 + 16 * a +: 16];
        end
        // Matrix product with exact sums, round half up, clamp to 32 bits.
        for (int r = 0; r < 3; r++) begin
            sum = '0;
            for (int j = 0; j < 3; j++) begin
                ma  = coef_shadow[base + MAT_BASE + r * 3 + j];
                va  = lin[j];
                sum = sum + ma * va;
            end
            sum = sum + (100'sd1 <<< 47);
            q   = sum >>> 48;
            if (q > 100'sd2147483647) begin
                w.rate[r] = 32'h7FFF_FFFF;
                w.sat     = 1'b1;
            end else if (q < -100'sd2147483648) begin
                w.rate[r] = 32'h8000_0000;
                w.sat     = 1'b1;
            end else begin
                w.rate[r] = q[31:0];
            end
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_rate_count = 0;
        o_sat_count  = 0;
        foreach (coef_shadow[i]) coef_shadow[i] = 0;
    end

    assign o_pending = rate_queue.size();

    // Input side: update the shadow table or queue a prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && i_s_tready && i_s_tdata[2:0] < NUM_IMUS) begin
            if (t_op'(i_s_tuser) == OP_LOAD) begin
                if (i_s_tdata[7:3] < ROW_WORDS) begin
                    coef_shadow[int'(i_s_tdata[2:0]) * ROW_WORDS + int'(i_s_tdata[7:3])] =
                        longint'($signed(i_s_tdata[55:8]));
                end
            end else begin
                rate_queue.push_back(calibrate(i_s_tdata));
            end
        end
    end

    // Output side: compare each word with the oldest prediction.
    always @(posedge i_clk) begin
        t_rate_word w;
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (rate_queue.size() == 0) begin
                $error("unexpected output word %h", i_m_tdata);
                o_fail_count++;
            end else begin
                w = rate_queue.pop_front();
                o_rate_count++;
                if (i_m_tuser[0]) o_sat_count++;
                check_field("imu_out", 32'(w.imu), 32'(i_m_tdata[2:0]));
                check_field("index_out", 32'(w.idx), 32'(i_m_tdata[10:3]));
                check_field("rate_x", w.rate[0], i_m_tdata[42:11]);
                check_field("rate_y", w.rate[1], i_m_tdata[74:43]);
                check_field("rate_z", w.rate[2], i_m_tdata[106:75]);
                check_field("accel_x_out", 32'(w.accel[0]), 32'(i_m_tdata[122:107]));
                check_field("accel_y_out", 32'(w.accel[1]), 32'(i_m_tdata[138:123]));
                check_field("accel_z_out", 32'(w.accel[2]), 32'(i_m_tdata[154:139]));
                check_field("saturated", 32'(w.sat), 32'(i_m_tuser[0]));
            end
        end
    end

endmodule

// ===== dv/gyro_cubic_and_matrix_calibration_test.sv =====
`timescale 1ns / 1ps

module gyro_cubic_and_matrix_calibration_test;
    import gcmc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;

    int fail_count;
    int pending;
    int rate_count;
    int sat_count;
    int send_gap_pct;
    int recv_stall_pct;
    bit hold_req;
    int cycles;
    int load_count;

    gyro_cubic_and_matrix_calibration uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    gcmc_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_rate_count (rate_count),
        .o_sat_count  (sat_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        bit hold_done;
        m_tready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [159:0] random_bits();
        logic [159:0] v;
        for (int i = 0; i < 5; i++) v[32 * i +: 32] = $urandom;
        return v;
    endfunction

    // Mostly moderate values within plus or minus one, with extremes and full-range words.
    function automatic logic [47:0] random_coef();
        logic [47:0] v;
        case ($urandom_range(9))
            0: v = 48'h7FFF_FFFF_FFFF;
            1: v = 48'h8000_0000_0000;
            2, 3: v = 48'({$urandom, $urandom});
            default: v = 48'($signed({$urandom, 1'b0}));
        endcase
        return v;
    endfunction

    // Offers one word and waits until the block takes it.
    task automatic send_word(input t_op op, input logic [159:0] d);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        if (op == OP_LOAD) load_count++;
    endtask

    task automatic load_word(input int imu, input int slot, input logic [47:0] v);
        logic [159:0] d;
        d = random_bits();
        d[2:0]  = 3'(imu);
        d[7:3]  = 5'(slot);
        d[55:8] = v;
        send_word(OP_LOAD, d);
    endtask

    // Loads a full row; kind 0 is unity polynomials with an identity matrix,
    // 1 the positive extreme, 2 the negative extreme, otherwise random.
    task automatic load_row(input int imu, input int kind);
        logic [47:0] v;
        for (int s = 0; s < ROW_WORDS; s++) begin
            case (kind)
                0: v = (s < MAT_BASE) ? ((s % POLY_TERMS == 1) ? 48'h1_0000_0000 : '0)
                                      : (((s - MAT_BASE) % 4 == 0) ? 48'h1_0000_0000 : '0);
                1: v = 48'h7FFF_FFFF_FFFF;
                2: v = 48'h8000_0000_0000;
                default: v = random_coef();
            endcase
            load_word(imu, s, v);
        end
    endtask

    task automatic sample_word(input int imu, input int gyro_kind);
        logic [159:0] d;
        d = random_bits();
        d[2:0] = 3'(imu);
        for (int a = 0; a < 3; a++) begin
            case (gyro_kind)
                1: d[64 + 16 * a +: 16] = 16'h7FFF;
                2: d[64 + 16 * a +: 16] = 16'h8000;
                3: d[64 + 16 * a +: 16] = 16'h0000;
                default: ;
            endcase
        end
        send_word(OP_SAMPLE, d);
    endtask

    task automatic random_item();
        int pick;
        int imu;
        pick = $urandom_range(99);
        imu  = $urandom_range(NUM_IMUS - 1);
        if (pick < 70) begin
            sample_word(imu, ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
        end else if (pick < 90) begin
            load_word(imu, $urandom_range(ROW_WORDS - 1), random_coef());
        end else if (pick < 95) begin
            load_word($urandom_range(7), $urandom_range(31), random_coef());
        end else begin
            sample_word($urandom_range(NUM_IMUS, 7), 0);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_LOAD;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        cycles         = 0;
        load_count     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unity calibration, extreme rows, ignored words.
        load_row(0, 0);
        for (int g = 0; g <= 3; g++) sample_word(0, g);
        load_row(1, 1);
        sample_word(1, 1);
        sample_word(1, 2);
        load_row(2, 2);
        sample_word(2, 1);
        sample_word(2, 2);
        load_word(0, 31, 48'h7FFF_FFFF_FFFF);
        load_word(7, 3, 48'h8000_0000_0000);
        sample_word(6, 1);
        sample_word(7, 2);
        drain();

        // Every row gets a random full load before random traffic.
        for (int i = 0; i < NUM_IMUS; i++) load_row(i, 3);

        // Random phases with different idle mixes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
                default: begin send_gap_pct = 29; recv_stall_pct = 29; end
            endcase
            if (ph == 2) begin
                // Long output hold-off while samples keep coming.
                hold_req = 1'b1;
                repeat (60) sample_word($urandom_range(NUM_IMUS - 1), 0);
                hold_req = 1'b0;
            end
            repeat (330) random_item();
        end
        drain();

        $display("Run covered %0d calibrated samples (%0d saturated) and %0d table loads.",
                 rate_count, sat_count, load_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
